FILE: rtl/p1305_pkg.sv
// shared types and constants for the poly1305 mac
package p1305_pkg;

    localparam logic [63:0] R_LOW_CLAMP  = 64'h0ffffffc0fffffff;
    localparam logic [63:0] R_HIGH_CLAMP = 64'h0ffffffc0ffffffc;

    // configuration register indexes
    localparam logic [1:0] CFG_R_LOW  = 2'd0;
    localparam logic [1:0] CFG_R_HIGH = 2'd1;
    localparam logic [1:0] CFG_S_LOW  = 2'd2;
    localparam logic [1:0] CFG_S_HIGH = 2'd3;

    // one job handed from front to back
    typedef struct packed {
        logic [127:0] blk;
        logic         absorb;
        logic         hibit;
        logic         emit;
    } p1305_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_CAN,
        ST_FIN,
        ST_OUT
    } p1305_state_t;

endpackage

FILE: rtl/p1305_front.sv
// byte gathering front end: builds blocks and padded final blocks
module p1305_front
    import p1305_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        is_last,
    input  logic        valid,
    output logic        ready,
    output logic        job_valid,
    input  logic        job_ready,
    output p1305_job_t  job
);

    logic [127:0] buf_reg, buf_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         jv_reg, jv_next;
    p1305_job_t   job_reg, job_next;

    assign ready     = !jv_reg || job_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    // classify the beat
    always_comb
    begin
        logic [127:0] b;
        logic [4:0]   n;
        b = buf_reg;
        n = {1'b0, cnt_reg};
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        job_next = job_reg;
        jv_next  = jv_reg && !job_ready;
        if (valid && ready)
        begin
            if (has_byte)
            begin
                b[cnt_reg*8 +: 8] = msg_byte;
                n = n + 5'd1;
            end
            job_next.blk    = b;
            job_next.absorb = 1'b0;
            job_next.hibit  = 1'b0;
            job_next.emit   = 1'b0;
            if (n == 5'd16)
            begin
                job_next.absorb = 1'b1;
                job_next.hibit  = 1'b1;
                n = 5'd0;
            end
            else if (is_last && n != 5'd0)
            begin
                // pad with 0x01 then zeros
                for (int k = 0; k < 16; k++)
                    if (k[4:0] == n) job_next.blk[k*8 +: 8] = 8'h01;
                    else if (k[4:0] > n) job_next.blk[k*8 +: 8] = 8'h00;
                job_next.absorb = 1'b1;
                n = 5'd0;
            end
            if (is_last)
            begin
                job_next.emit = 1'b1;
                n = 5'd0;
            end
            buf_next = b;
            cnt_next = n[3:0];
            jv_next  = job_next.absorb || job_next.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            jv_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            jv_reg  <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        job_reg <= job_next;
    end

endmodule

FILE: rtl/p1305_core.sv
// back end: multiply mod 2^130-5, final reduction and pad add
module p1305_core
    import p1305_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    output logic         job_ready,
    input  p1305_job_t   job,
    input  logic [63:0]  r_low,
    input  logic [63:0]  r_high,
    input  logic [63:0]  s_low,
    input  logic [63:0]  s_high,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [127:0] tag
);

    p1305_state_t     state_reg, state_next;
    logic [4:0][25:0] acc_reg, acc_next;
    logic [4:0][26:0] h_reg, h_next;
    logic [4:0][25:0] r_reg, r_next;
    logic [4:0][63:0] d_reg, d_next;
    logic [2:0]       i_reg, i_next;
    logic [2:0]       j_reg, j_next;
    logic [1:0]       pass_reg, pass_next;
    logic             emit_reg, emit_next;
    logic [127:0]     tag_reg, tag_next;

    logic [129:0] msg_val;
    logic [129:0] r_val;
    logic [129:0] acc_val;
    logic [129:0] d_val;
    logic [130:0] d_plus5;
    logic [2:0]   k_lo, k_wrap;
    logic [26:0]  h_sel;
    logic [28:0]  r_sel;
    logic [55:0]  prod;
    logic [37:0]  carry;
    logic [63:0]  carry5;

    // block value with its high bit, and clamped r
    assign msg_val = {1'b0, job.hibit, job.blk};
    assign r_val   = {2'b00, r_high & R_HIGH_CLAMP, r_low & R_LOW_CLAMP};
    assign acc_val = acc_reg;

    // one limb product per cycle: column i, term j, upper terms folded by five
    assign k_lo   = i_reg - j_reg;
    assign k_wrap = i_reg + 3'd5 - j_reg;
    assign h_sel  = h_reg[j_reg];
    assign r_sel  = (i_reg >= j_reg) ? {3'd0, r_reg[k_lo]}
                                     : {3'd0, r_reg[k_wrap]} + {1'b0, r_reg[k_wrap], 2'b00};
    assign prod   = {29'd0, h_sel} * {27'd0, r_sel};

    // carry out of the limb under reduction
    assign carry  = d_reg[i_reg][63:26];
    assign carry5 = {26'd0, carry} + {24'd0, carry, 2'b00};

    // packed limbs and the trial subtract of p
    assign d_val   = {d_reg[4][25:0], d_reg[3][25:0], d_reg[2][25:0],
                      d_reg[1][25:0], d_reg[0][25:0]};
    assign d_plus5 = {1'b0, d_val} + 131'd5;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign tag       = tag_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = job.absorb ? ST_MUL : ST_FIN;
            ST_MUL:  if (i_reg == 3'd4 && j_reg == 3'd4) state_next = ST_RED;
            ST_RED:  if (pass_reg == 2'd2 && i_reg == 3'd4) state_next = ST_CAN;
            ST_CAN:  state_next = emit_reg ? ST_FIN : ST_IDLE;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath: 25 limb products, three carry passes, one trial subtract
    always_comb
    begin
        acc_next  = acc_reg;
        h_next    = h_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        pass_next = pass_reg;
        emit_next = emit_reg;
        tag_next  = tag_reg;
        unique case (state_reg)
            ST_IDLE:
                if (job_valid)
                begin
                    emit_next = job.emit;
                    for (int k = 0; k < 5; k++)
                    begin
                        h_next[k] = {1'b0, acc_reg[k]} + {1'b0, msg_val[k*26 +: 26]};
                        r_next[k] = r_val[k*26 +: 26];
                    end
                    d_next = '0;
                    i_next = '0;
                    j_next = '0;
                end
            ST_MUL:
            begin
                d_next[i_reg] = d_reg[i_reg] + {8'd0, prod};
                if (j_reg == 3'd4)
                begin
                    j_next = '0;
                    i_next = (i_reg == 3'd4) ? 3'd0 : i_reg + 3'd1;
                end
                else
                    j_next = j_reg + 3'd1;
                pass_next = '0;
            end
            ST_RED:
            begin
                d_next[i_reg] = {38'd0, d_reg[i_reg][25:0]};
                if (i_reg == 3'd4)
                begin
                    // wrap 2^130 back as five
                    d_next[0] = d_reg[0] + carry5;
                    i_next    = '0;
                    pass_next = pass_reg + 2'd1;
                end
                else
                begin
                    d_next[i_reg + 3'd1] = d_reg[i_reg + 3'd1] + {26'd0, carry};
                    i_next = i_reg + 3'd1;
                end
            end
            ST_CAN:
                // canonical: subtract p once if needed
                if (d_plus5[130])
                    acc_next = d_plus5[129:0];
                else
                    acc_next = d_val;
            ST_FIN:
            begin
                tag_next = acc_val[127:0] + {s_high, s_low};
                acc_next = '0;
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        pass_reg <= pass_next;
        emit_reg <= emit_next;
        tag_reg  <= tag_next;
    end

endmodule

FILE: rtl/poly1305_mac.sv
// top level of the poly1305 authenticator
//  channel | signals                         | direction
//  in      | valid ready msg_byte has_byte is_last | in
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | in
//  out     | out_valid out_ready tag_low tag_high  | out
// bytes are taken at one per cycle while the one-entry job queue has room
// a full or padded block holds the back end through load, 25 limb
// products, 15 carry steps and the final subtract
// the tag is valid in ST_OUT, which follows ST_FIN once the back end takes
// the finishing job or finishes the last block; a waiting tag holds the back end
// reset clears the count, accumulator and key registers
module poly1305_mac
    import p1305_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        is_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high
);

    logic [63:0]  r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    logic         job_valid, job_ready;
    p1305_job_t   job;
    logic [127:0] tag;

    assign cfg_ready = 1'b1;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg  <= '0;
            r_high_reg <= '0;
            s_low_reg  <= '0;
            s_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_R_LOW:  r_low_reg  <= cfg_data;
                CFG_R_HIGH: r_high_reg <= cfg_data;
                CFG_S_LOW:  s_low_reg  <= cfg_data;
                CFG_S_HIGH: s_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    p1305_front u_front (
        .clk(clk), .rst_n(rst_n), .msg_byte(msg_byte), .has_byte(has_byte),
        .is_last(is_last), .valid(valid), .ready(ready),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    p1305_core u_core (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
        .job(job), .r_low(r_low_reg), .r_high(r_high_reg), .s_low(s_low_reg),
        .s_high(s_high_reg), .out_valid(out_valid), .out_ready(out_ready),
        .tag(tag)
    );

    assign tag_low  = tag[63:0];
    assign tag_high = tag[127:64];

endmodule

FILE: rtl/p1305_checker.sv
// port-level checks for the poly1305 mac
module p1305_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] tag_low,
    input logic        cfg_ready
);

    // a waiting tag stays valid and its low half holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tag_low))
        else $error("tag changed while stalled");

    // config port always open
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");

    // a taken tag is not shown again at once
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("tag repeated");

endmodule

bind poly1305_mac p1305_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .tag_low(tag_low), .cfg_ready(cfg_ready)
);

FILE: sim/poly1305_checker.sv
// checker: predicts poly1305 tags from the watched channels and compares them
module poly1305_checker
    import p1305_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic        ready,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        is_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] tag_low,
    input  logic [63:0] tag_high,
    output int          fails,
    output int          pending
);

    localparam logic [263:0] PRIME = (264'd1 << 130) - 264'd5;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } tag_t;

    tag_t         tag_q[$];
    logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [129:0] acc;
    logic [7:0]   blk_bytes[16];
    int           nbytes;

    assign pending = tag_q.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // acc = (acc + block) * clamped r mod 2^130-5
    function automatic logic [129:0] absorb_block(input logic [129:0] a,
                                                  input logic [128:0] m,
                                                  input logic [63:0] rl,
                                                  input logic [63:0] rh);
        logic [263:0] x;
        logic [263:0] r;
        r = {136'd0, rh & R_HIGH_CLAMP, rl & R_LOW_CLAMP};
        x = ({134'd0, a} + {135'd0, m}) * r;
        for (int k = 0; k < 3; k++)
            x = {134'd0, x[129:0]} + (x >> 130) * 264'd5;
        while (x >= PRIME)
            x = x - PRIME;
        return x[129:0];
    endfunction

    function automatic logic [127:0] block_value();
        logic [127:0] v;
        v = '0;
        for (int k = 0; k < 16; k++)
            v[k*8 +: 8] = blk_bytes[k];
        return v;
    endfunction

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        tag_t         t;
        logic [127:0] sum;
        if (!rst_n)
        begin
            key_r_lo = '0; key_r_hi = '0; key_s_lo = '0; key_s_hi = '0;
            acc = '0;
            nbytes = 0;
            fails = 0;
            tag_q.delete();
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_R_LOW:  key_r_lo = cfg_data;
                    CFG_R_HIGH: key_r_hi = cfg_data;
                    CFG_S_LOW:  key_s_lo = cfg_data;
                    CFG_S_HIGH: key_s_hi = cfg_data;
                endcase
            end
            // message beat
            if (valid && ready)
            begin
                if (has_byte)
                begin
                    blk_bytes[nbytes] = msg_byte;
                    nbytes++;
                    if (nbytes == 16)
                    begin
                        acc = absorb_block(acc, {1'b1, block_value()}, key_r_lo, key_r_hi);
                        nbytes = 0;
                    end
                end
                if (is_last)
                begin
                    // partial block gets the 0x01 pad and no high bit
                    if (nbytes != 0)
                    begin
                        blk_bytes[nbytes] = 8'h01;
                        for (int k = nbytes + 1; k < 16; k++)
                            blk_bytes[k] = 8'h00;
                        acc = absorb_block(acc, {1'b0, block_value()}, key_r_lo, key_r_hi);
                    end
                    sum = acc[127:0] + {key_s_hi, key_s_lo};
                    t.lo = sum[63:0];
                    t.hi = sum[127:64];
                    tag_q.push_back(t);
                    acc = '0;
                    nbytes = 0;
                end
            end
            // tag beat
            if (out_valid && out_ready)
            begin
                if (tag_q.size() == 0)
                    report("unexpected tag_low", tag_low, '0);
                else
                begin
                    t = tag_q.pop_front();
                    if (tag_low !== t.lo)
                        report("tag_low", tag_low, t.lo);
                    if (tag_high !== t.hi)
                        report("tag_high", tag_high, t.hi);
                end
            end
        end
    end

endmodule

FILE: sim/tb.sv
// testbench top: stimulus, idling and verdict for poly1305_mac
module tb
    import p1305_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_byte;
    logic        has_byte;
    logic        is_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] tag_low;
    logic [63:0] tag_high;
    int          fails;
    int          pending;
    int          idle_cycles;
    bit          holdoff_done;

    poly1305_mac dut (.*);

    poly1305_checker chk (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic hb, input logic last);
        int g;
        g = gap_len();
        repeat (g)
        begin
            @(negedge clk);
            valid = 1'b0;
        end
        @(negedge clk);
        valid = 1'b1;
        msg_byte = b;
        has_byte = hb;
        is_last = last;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++)
            send_beat(8'($urandom), 1'b1, 1'b0);
        send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // message whose last byte rides on the finishing beat
    task automatic send_message_joined(input int len);
        for (int k = 0; k < len - 1; k++)
            send_beat(8'($urandom), 1'b1, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
        @(negedge clk);
        valid = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait for the block to drain before touching the key
    task automatic drain();
        @(negedge clk);
        valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_key(input logic [63:0] rl, input logic [63:0] rh,
                            input logic [63:0] sl, input logic [63:0] sh);
        drain();
        write_reg(CFG_R_LOW, rl);
        write_reg(CFG_R_HIGH, rh);
        write_reg(CFG_S_LOW, sl);
        write_reg(CFG_S_HIGH, sh);
    endtask

    task automatic random_phase(input int msgs);
        int p;
        for (int m = 0; m < msgs; m++)
        begin
            p = $urandom_range(0, 99);
            if (p < 8)
                send_beat(8'($urandom), 1'b0, 1'b0);
            else if (p < 14)
                send_beat(8'($urandom), 1'b0, 1'b1);
            else if (p < 60)
                send_message($urandom_range(1, 20));
            else if (p < 85)
                send_message_joined($urandom_range(1, 34));
            else
                send_message(16 * $urandom_range(1, 2));
        end
    endtask

    // receiver: one long hold-off first, then random stalls
    initial
    begin
        out_ready = 1'b0;
        holdoff_done = 1'b0;
        @(posedge rst_n);
        repeat (400) @(negedge clk);
        holdoff_done = 1'b1;
        forever
        begin
            @(negedge clk);
            out_ready = (gap_len() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // watchdog on cycles with no beat anywhere
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((valid && ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 5000)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        msg_byte = '0;
        has_byte = 1'b0;
        is_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_R_LOW;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero key, then a long message while the receiver holds off
        send_beat(8'h00, 1'b0, 1'b1);
        send_message(40);
        send_beat(8'hff, 1'b1, 1'b1);

        // all-ones key: extremes and boundary lengths
        load_key('1, '1, '1, '1);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_message(15);
        send_message(16);
        send_message_joined(16);
        send_message(17);
        send_message_joined(1);

        // key change in the middle of a message
        load_key(64'($urandom) << 32 | 64'($urandom), 64'($urandom) << 32 | 64'($urandom),
                 '0, '1);
        for (int k = 0; k < 20; k++)
            send_beat(8'($urandom), 1'b1, 1'b0);
        drain();
        write_reg(CFG_R_LOW, {$urandom, $urandom});
        write_reg(CFG_S_LOW, '1);
        send_message_joined(5);

        // random keys with random traffic
        while (!holdoff_done)
            @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            load_key({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
            random_phase(7);
        end

        @(negedge clk);
        valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
